/* hw/rtl/blist_pkg.sv */
// ----------------------------------------------------------------------------
// blist_pkg
// Shared types and constants for the bounded ordered list.
// ----------------------------------------------------------------------------
package blist_pkg;

	localparam int LIST_CAPACITY = 64;
	localparam int IDX_W         = 6;
	localparam int CNT_W         = 7;
	localparam int GRP_W         = 3;
	localparam int GRP_N         = 8;
	localparam int NGRP          = LIST_CAPACITY / GRP_N;
	localparam int NGRP_W        = IDX_W - GRP_W;
	localparam int VAL_W         = 32;
	localparam int FUNC_W        = 4;
	localparam int IN_W          = 48;
	localparam int OUT_W         = 56;

	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd0;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 4'd1;
	localparam logic [FUNC_W-1:0] FN_REM_FRONT = 4'd2;
	localparam logic [FUNC_W-1:0] FN_REM_BACK  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_INSERT_AT = 4'd4;
	localparam logic [FUNC_W-1:0] FN_REMOVE_AT = 4'd5;
	localparam logic [FUNC_W-1:0] FN_SEARCH    = 4'd6;
	localparam logic [FUNC_W-1:0] FN_SELECT    = 4'd7;
	localparam logic [FUNC_W-1:0] FN_REPLACE   = 4'd8;

	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_REM  = 2'd2;
	localparam logic [1:0] CELL_WR   = 2'd3;

	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pos;
		val_t             wval;
	} cell_cmd_t;

endpackage

/* hw/rtl/blist_cell.sv */
// ----------------------------------------------------------------------------
// blist_cell
// One list slot: shifts from its neighbors on insert/remove, compares to key.
// ----------------------------------------------------------------------------
module blist_cell (
	input  logic                          clk,
	input  logic [blist_pkg::IDX_W-1:0]   index,
	input  blist_pkg::cell_cmd_t          cmd,
	input  blist_pkg::val_t               left,
	input  blist_pkg::val_t               right,
	input  blist_pkg::val_t               key,
	output blist_pkg::val_t               value,
	output logic                          match
);
	import blist_pkg::*;

	val_t value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (index == cmd.pos) begin
					value_q <= cmd.wval;
				end else if (index > cmd.pos) begin
					value_q <= left;
				end
			end
			CELL_REM: begin
				if (index >= cmd.pos) begin
					value_q <= right;
				end
			end
			CELL_WR: begin
				if (index == cmd.pos) begin
					value_q <= cmd.wval;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule

/* hw/rtl/blist_reduce.sv */
// ----------------------------------------------------------------------------
// blist_reduce
// Registered two-level first-match encoder and position mux over the cells.
// ----------------------------------------------------------------------------
module blist_reduce (
	input  logic                                   clk,
	input  logic [blist_pkg::LIST_CAPACITY-1:0]    match,
	input  blist_pkg::val_t                        vals [blist_pkg::LIST_CAPACITY],
	input  logic [blist_pkg::CNT_W-1:0]            count,
	input  logic [blist_pkg::IDX_W-1:0]            sel,
	output logic [blist_pkg::CNT_W-1:0]            found,
	output blist_pkg::val_t                        rd
);
	import blist_pkg::*;

	logic [LIST_CAPACITY-1:0] mask;
	logic [LIST_CAPACITY-1:0] match_s1;
	logic [NGRP-1:0]          grp_hit;
	logic [GRP_W-1:0]         grp_idx [NGRP];
	logic [NGRP-1:0]          grp_hit_s2;
	logic [GRP_W-1:0]         grp_idx_s2 [NGRP];
	val_t                     grp_val_s2 [NGRP];

	always_comb begin
		for (int i = 0; i < LIST_CAPACITY; i++) begin
			mask[i] = (CNT_W'(i) < count);
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_hit[g] = |match_s1[g*GRP_N +: GRP_N];
			grp_idx[g] = '0;
			for (int j = GRP_N - 1; j >= 0; j--) begin
				if (match_s1[g*GRP_N + j]) begin
					grp_idx[g] = GRP_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		match_s1   <= match & mask;
		grp_hit_s2 <= grp_hit;
		for (int g = 0; g < NGRP; g++) begin
			grp_idx_s2[g] <= grp_idx[g];
			grp_val_s2[g] <= vals[{NGRP_W'(g), sel[GRP_W-1:0]}];
		end
	end

	always_comb begin
		found = count;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_hit_s2[g]) begin
				found = CNT_W'({NGRP_W'(g), grp_idx_s2[g]});
			end
		end
	end

	assign rd = grp_val_s2[sel[IDX_W-1:GRP_W]];

endmodule

/* hw/rtl/bounded_ordered_list_top.sv */
// Insert, remove, replace and refused requests give their result the cycle
// after acceptance and sustain one per cycle while m_tready is high; select
// passes a group mux and a final mux, search a registered compare, a group
// encode and a final encode. One request is in flight at a time. Reset clears
// the count and control state; cell contents stay undefined until written.
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to 64 values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func[3:0], position[10:4], elem_value[42:11], zero pad
	input  logic [blist_pkg::IN_W-1:0]    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ok[0], read_value[32:1], found_index[39:33], count[46:40],
	// is_full[47], is_empty[48], zero pad
	output logic [blist_pkg::OUT_W-1:0]   m_tdata
);
	import blist_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SRCH_CMP = 3'd1;
	localparam logic [2:0] ST_SRCH_GRP = 3'd2;
	localparam logic [2:0] ST_SRCH_FIN = 3'd3;
	localparam logic [2:0] ST_SEL_GRP  = 3'd4;
	localparam logic [2:0] ST_SEL_FIN  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;

	logic [FUNC_W-1:0] func;
	logic [CNT_W-1:0]  position;
	val_t              elem_value;
	logic              accept;

	cell_cmd_t         cmd;
	cell_cmd_t         cell_cmd;
	logic              ok_c;
	logic              multi;
	logic [CNT_W-1:0]  cnt_n;
	logic [CNT_W-1:0]  cnt_m1;
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  sel_idx;

	val_t              key_q;
	logic [IDX_W-1:0]  sel_q;
	logic              out_ok_q;
	val_t              out_rd_q;
	logic [CNT_W-1:0]  out_found_q;
	logic [CNT_W-1:0]  out_cnt_q;

	val_t                     vals [LIST_CAPACITY];
	logic [LIST_CAPACITY-1:0] match;
	logic [CNT_W-1:0]         found;
	val_t                     rd;

	assign func       = s_tdata[3:0];
	assign position   = s_tdata[10:4];
	assign elem_value = s_tdata[42:11];

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign full    = (count_q == CNT_W'(LIST_CAPACITY));
	assign empty   = (count_q == '0);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign sel_idx = (position < count_q) ? position[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

	always_comb begin
		cmd   = '{op: CELL_HOLD, pos: '0, wval: elem_value};
		ok_c  = 1'b0;
		multi = 1'b0;
		cnt_n = count_q;
		case (func)
			FN_INS_FRONT: begin
				if (!full) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_INS;
					cnt_n   = count_q + CNT_W'(1);
				end
			end
			FN_INS_BACK: begin
				if (!full) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_INS;
					cmd.pos = count_q[IDX_W-1:0];
					cnt_n   = count_q + CNT_W'(1);
				end
			end
			FN_INSERT_AT: begin
				if (!full && position <= count_q) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_INS;
					cmd.pos = position[IDX_W-1:0];
					cnt_n   = count_q + CNT_W'(1);
				end
			end
			FN_REM_FRONT: begin
				if (!empty) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_REM;
					cnt_n   = cnt_m1;
				end
			end
			FN_REM_BACK: begin
				if (!empty) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_REM;
					cmd.pos = cnt_m1[IDX_W-1:0];
					cnt_n   = cnt_m1;
				end
			end
			FN_REMOVE_AT: begin
				if (position < count_q) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_REM;
					cmd.pos = position[IDX_W-1:0];
					cnt_n   = cnt_m1;
				end
			end
			FN_REPLACE: begin
				if (position < count_q) begin
					ok_c    = 1'b1;
					cmd.op  = CELL_WR;
					cmd.pos = position[IDX_W-1:0];
				end
			end
			FN_SEARCH: begin
				multi = 1'b1;
			end
			FN_SELECT: begin
				multi = !empty;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cell_cmd = cmd;
		if (!accept) begin
			cell_cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
		val_t left_v;
		val_t right_v;
		if (i == 0) begin : g_first
			assign left_v = vals[0];
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == LIST_CAPACITY - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end
		blist_cell u_cell (
			.clk   (clk),
			.index (IDX_W'(i)),
			.cmd   (cell_cmd),
			.left  (left_v),
			.right (right_v),
			.key   (key_q),
			.value (vals[i]),
			.match (match[i])
		);
	end

	blist_reduce u_reduce (
		.clk   (clk),
		.match (match),
		.vals  (vals),
		.count (count_q),
		.sel   (sel_q),
		.found (found),
		.rd    (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_n;
						if (multi) begin
							state_q <= (func == FN_SEARCH) ? ST_SRCH_CMP : ST_SEL_GRP;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_SRCH_CMP: state_q <= ST_SRCH_GRP;
				ST_SRCH_GRP: state_q <= ST_SRCH_FIN;
				ST_SEL_GRP:  state_q <= ST_SEL_FIN;
				ST_SRCH_FIN, ST_SEL_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= elem_value;
			sel_q <= sel_idx;
			if (!multi) begin
				out_ok_q    <= ok_c;
				out_rd_q    <= '0;
				out_found_q <= '0;
				out_cnt_q   <= cnt_n;
			end
		end
		if (state_q == ST_SRCH_FIN) begin
			out_ok_q    <= 1'b1;
			out_rd_q    <= '0;
			out_found_q <= found;
			out_cnt_q   <= count_q;
		end
		if (state_q == ST_SEL_FIN) begin
			out_ok_q    <= 1'b1;
			out_rd_q    <= rd;
			out_found_q <= '0;
			out_cnt_q   <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		7'd0,
		(out_cnt_q == '0),
		(out_cnt_q == CNT_W'(LIST_CAPACITY)),
		out_cnt_q,
		out_found_q,
		out_rd_q,
		out_ok_q
	};

endmodule
